FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTL files that check their own behaviour.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/brhr_pkg.sv
// ---------------------------------------------------------------------------
// brhr_pkg
// Types, codes and helpers for the byte range header resolver.
// ---------------------------------------------------------------------------
package brhr_pkg;

  // Width of a range bound; sizes saturate at 2^OFFSET_BITS-1, a bound past it is malformed
  localparam int unsigned OFFSET_BITS = 64;
  localparam int unsigned ACC_BITS    = OFFSET_BITS + 4;

  localparam logic [OFFSET_BITS-1:0] BOUND_MAX = '1;
  localparam logic [63:0]            SIZE_MAX  = 64'(BOUND_MAX);

  // Characters of interest
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_UNSAT     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_CLOSED = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_SUFFIX = 2'd2
  } kind_t;

  // One header byte
  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [63:0] object_size;
  } brhr_in_t;

  // One resolved range
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  range_kind;
    logic [63:0] start_offset;
    logic [63:0] span_length;
  } brhr_out_t;

  // Parser state handed to the resolve stage at the last byte
  typedef struct packed {
    logic                   bad;
    logic                   in_hi;
    logic                   first_has;
    logic                   second_has;
    logic [OFFSET_BITS-1:0] first_bound;
    logic [OFFSET_BITS-1:0] second_bound;
    logic [OFFSET_BITS-1:0] size;
  } brhr_parsed_t;

  // Expected character at each place of the unit prefix "bytes="
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/brhr_parse.sv
// ---------------------------------------------------------------------------
// brhr_parse
// Per-byte parser: skips outer blanks, matches the unit prefix and
// accumulates both decimal bounds with an overflow check.
// ---------------------------------------------------------------------------
module brhr_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  brhr_pkg::brhr_in_t    item,
  output brhr_pkg::brhr_parsed_t snap
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_PREFIX,
    PH_LO,
    PH_HI
  } phase_t;

  phase_t                           phase, phase_next;
  logic [2:0]                       prefix_pos, prefix_pos_next;
  logic [brhr_pkg::OFFSET_BITS-1:0] first_bound, first_bound_next;
  logic [brhr_pkg::OFFSET_BITS-1:0] second_bound, second_bound_next;
  logic                             first_has, first_has_next;
  logic                             second_has, second_has_next;
  logic                             blank_after, blank_after_next;
  logic                             bad, bad_next;

  logic                             is_blank;
  logic                             is_digit;
  logic [3:0]                       digit;
  logic [brhr_pkg::OFFSET_BITS-1:0] acc;
  logic [brhr_pkg::ACC_BITS-1:0]    prod;
  logic                             ovf;
  logic                             acc_has;

  // Shared decimal accumulate: acc * 10 + digit
  // ASCII digits carry their value in the low nibble
  assign is_blank   = (item.ch == brhr_pkg::CH_SPACE) || (item.ch == brhr_pkg::CH_TAB);
  assign is_digit   = (item.ch >= brhr_pkg::CH_ZERO) && (item.ch <= brhr_pkg::CH_NINE);
  assign digit      = item.ch[3:0];
  assign acc        = (phase == PH_HI) ? second_bound : first_bound;
  assign acc_has    = (phase == PH_HI) ? second_has : first_has;
  assign prod       = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
                    + brhr_pkg::ACC_BITS'(digit);
  assign ovf        = |prod[brhr_pkg::ACC_BITS-1:brhr_pkg::OFFSET_BITS];

  // Advance the parse by one byte
  always_comb begin
    phase_next        = phase;
    prefix_pos_next   = prefix_pos;
    first_bound_next  = first_bound;
    second_bound_next = second_bound;
    first_has_next    = first_has;
    second_has_next   = second_has;
    blank_after_next  = blank_after;
    bad_next          = bad;
    if (!bad) begin
      unique case (phase)
        PH_LEAD, PH_PREFIX: begin
          if (phase == PH_LEAD && is_blank) begin
            phase_next = PH_LEAD;
          end else if (item.ch != brhr_pkg::prefix_char(
                         (phase == PH_LEAD) ? 3'd0 : prefix_pos)) begin
            bad_next = 1'b1;
          end else begin
            prefix_pos_next = ((phase == PH_LEAD) ? 3'd0 : prefix_pos) + 3'd1;
            phase_next = (prefix_pos_next == brhr_pkg::PREFIX_LEN) ? PH_LO : PH_PREFIX;
          end
        end
        PH_LO, PH_HI: begin
          if (phase == PH_LO && item.ch == brhr_pkg::CH_DASH) begin
            phase_next       = PH_HI;
            blank_after_next = 1'b0;
          end else if (is_blank) begin
            if (acc_has) begin
              blank_after_next = 1'b1;
            end
          end else if (is_digit) begin
            if (blank_after || ovf) begin
              bad_next = 1'b1;
            end else if (phase == PH_HI) begin
              second_bound_next = prod[brhr_pkg::OFFSET_BITS-1:0];
              second_has_next   = 1'b1;
            end else begin
              first_bound_next = prod[brhr_pkg::OFFSET_BITS-1:0];
              first_has_next   = 1'b1;
            end
          end else begin
            bad_next = 1'b1;
          end
        end
        default: bad_next = 1'b1;
      endcase
    end
  end

  // Hand the parsed value and saturated size to the resolve stage
  always_comb begin
    snap.bad          = bad_next;
    snap.in_hi        = (phase_next == PH_HI);
    snap.first_has    = first_has_next;
    snap.second_has   = second_has_next;
    snap.first_bound  = first_bound_next;
    snap.second_bound = second_bound_next;
    snap.size         = (item.object_size > brhr_pkg::SIZE_MAX) ? brhr_pkg::BOUND_MAX
                      : item.object_size[brhr_pkg::OFFSET_BITS-1:0];
  end

  // Hold parse state; drop back to the start after the last byte
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      phase        <= PH_LEAD;
      prefix_pos   <= 3'd0;
      first_bound  <= '0;
      second_bound <= '0;
      first_has    <= 1'b0;
      second_has   <= 1'b0;
      blank_after  <= 1'b0;
      bad          <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      prefix_pos   <= prefix_pos_next;
      first_bound  <= first_bound_next;
      second_bound <= second_bound_next;
      first_has    <= first_has_next;
      second_has   <= second_has_next;
      blank_after  <= blank_after_next;
      bad          <= bad_next;
    end
  end

endmodule

FILE: hw/rtl/byte_range_header_resolver.sv
// The result of a value goes from the input register through the parse stage into the
// s2 register, then through the resolve stage into the result register.
// Throughput: 1 byte per cycle, limited by the parse step, while no last byte waits for room downstream.
// Bytes without the last mark produce no result and never wait on the output.
// Reset (rst, synchronous): empties all stages and returns the parser to the
// leading-blank state; no clearing pass.
// ---------------------------------------------------------------------------
// byte_range_header_resolver
// Resolves one HTTP byte range, fed a byte per item, against the object size.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_range_header_resolver (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  brhr_pkg::brhr_in_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output brhr_pkg::brhr_out_t result
);

  logic                   s1_valid;
  brhr_pkg::brhr_in_t     s1;
  logic                   s2_valid;
  brhr_pkg::brhr_parsed_t s2;
  brhr_pkg::brhr_parsed_t snap;
  brhr_pkg::brhr_out_t    resolved;

  logic s2_take;
  logic s2_free;
  logic s1_adv;

  // Stage flow: only a last byte needs room downstream
  assign s2_take    = !result_valid || result_ready;
  assign s2_free    = !s2_valid || s2_take;
  assign s1_adv     = s1_valid && (!s1.last || s2_free);
  assign item_ready = !s1_valid || s1_adv;

  brhr_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .item (s1),
    .snap (snap)
  );

  // Resolve the parsed range against the size
  always_comb begin
    logic [brhr_pkg::OFFSET_BITS-1:0] size;
    logic [brhr_pkg::OFFSET_BITS-1:0] first;
    logic [brhr_pkg::OFFSET_BITS-1:0] second;
    logic [brhr_pkg::OFFSET_BITS-1:0] n;
    logic [brhr_pkg::OFFSET_BITS-1:0] last_byte;
    logic [brhr_pkg::OFFSET_BITS-1:0] stop;
    logic [brhr_pkg::OFFSET_BITS-1:0] start;
    logic [brhr_pkg::OFFSET_BITS-1:0] len;
    size      = s2.size;
    first     = s2.first_bound;
    second    = s2.second_bound;
    n         = (second < size) ? second : size;
    last_byte = size - brhr_pkg::OFFSET_BITS'(1);
    stop      = (second < last_byte) ? second : last_byte;
    start     = '0;
    len       = '0;
    resolved.status     = brhr_pkg::ST_MALFORMED;
    resolved.range_kind = brhr_pkg::KIND_CLOSED;
    if (!s2.bad && s2.in_hi) begin
      if (!s2.first_has) begin
        if (s2.second_has && second != '0) begin
          resolved.range_kind = brhr_pkg::KIND_SUFFIX;
          if (size == '0) begin
            resolved.status = brhr_pkg::ST_UNSAT;
          end else begin
            resolved.status = brhr_pkg::ST_OK;
            start = size - n;
            len   = n;
          end
        end
      end else if (!s2.second_has) begin
        resolved.range_kind = brhr_pkg::KIND_OPEN;
        if (first >= size) begin
          resolved.status = brhr_pkg::ST_UNSAT;
        end else begin
          resolved.status = brhr_pkg::ST_OK;
          start = first;
          len   = size - first;
        end
      end else if (second >= first) begin
        resolved.range_kind = brhr_pkg::KIND_CLOSED;
        if (first >= size) begin
          resolved.status = brhr_pkg::ST_UNSAT;
        end else begin
          resolved.status = brhr_pkg::ST_OK;
          start = first;
          len   = stop - first + brhr_pkg::OFFSET_BITS'(1);
        end
      end
    end
    resolved.start_offset = 64'(start);
    resolved.span_length  = 64'(len);
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_adv && s1.last;
      end
      if (s2_take) begin
        result_valid <= s2_valid;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1 <= item;
    end
    if (s1_adv && s1.last) begin
      s2 <= snap;
    end
    if (s2_take && s2_valid) begin
      result <= resolved;
    end
  end

  // Checks
  `ASSERT_NEXT(a_last_reaches_resolve, clk, rst, s1_adv && s1.last, s2_valid,
               "last byte lost before resolve")
  `ASSERT_IMPLY(a_ok_nonempty, clk, rst,
                result_valid && result.status == brhr_pkg::ST_OK,
                result.span_length != 64'd0, "ok result with empty span")
  `ASSERT_IMPLY(a_fail_zero, clk, rst,
                result_valid && result.status != brhr_pkg::ST_OK,
                result.start_offset == 64'd0 && result.span_length == 64'd0,
                "failed result with nonzero range")

endmodule
